>>> rtl/hsfr_pkg.sv
// ----------------------------------------------------------------------------
// hsfr_pkg
// Types and constants shared by the header-sync frame receiver files.
// ----------------------------------------------------------------------------
package hsfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SKIP_W    = 16;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_BYTE  = 2'd0,
    REG_FRAME_LENGTH = 2'd1,
    REG_SKIP_LIMIT   = 2'd2
  } cfg_reg_t;

  // Register values after reset
  localparam logic [BYTE_W-1:0] HEADER_BYTE_RST  = 8'd0;
  localparam logic [BYTE_W-1:0] FRAME_LENGTH_RST = 8'd31;
  localparam logic [SKIP_W-1:0] SKIP_LIMIT_RST   = 16'd100;

  // Shortest frame: header plus two trailer bytes
  localparam logic [BYTE_W-1:0] MIN_FRAME_LENGTH = 8'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [BYTE_W-1:0] byte_index;
    logic              frame_end;
    logic              checksum_bad;
    logic              forced_start;
  } out_item_t;

  // Handoff from the framing logic to the result buffer
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } out_push_t;

endpackage

>>> rtl/hsfr_in_if.sv
// ----------------------------------------------------------------------------
// hsfr_in_if
// Received byte channel: valid/ready with one byte of payload.
// ----------------------------------------------------------------------------
interface hsfr_in_if;
  logic                        valid;
  logic                        ready;
  logic [hsfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/hsfr_out_if.sv
// ----------------------------------------------------------------------------
// hsfr_out_if
// Frame byte channel: valid/ready with the byte, its index and status flags.
// ----------------------------------------------------------------------------
interface hsfr_out_if;
  logic                        valid;
  logic                        ready;
  logic [hsfr_pkg::BYTE_W-1:0] frame_byte;
  logic [hsfr_pkg::BYTE_W-1:0] byte_index;
  logic                        frame_end;
  logic                        checksum_bad;
  logic                        forced_start;

  modport source (output valid, output frame_byte, output byte_index,
                  output frame_end, output checksum_bad, output forced_start,
                  input ready);
  modport sink   (input valid, input frame_byte, input byte_index,
                  input frame_end, input checksum_bad, input forced_start,
                  output ready);
endinterface

>>> rtl/hsfr_cfg_if.sv
// ----------------------------------------------------------------------------
// hsfr_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface hsfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hsfr_pkg::CFG_IDX_W-1:0] index;
  logic [hsfr_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/hsfr_out_buf.sv
// ----------------------------------------------------------------------------
// hsfr_out_buf
// Result register with a skid stage, so the source side keeps flowing
// while a finished transaction waits on the sink.
// ----------------------------------------------------------------------------
module hsfr_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  hsfr_pkg::out_push_t push,
  output logic                push_ready,
  hsfr_out_if.source          out_ch
);

  logic                main_vld_r;
  logic                skid_vld_r;
  hsfr_pkg::out_item_t main_r;
  hsfr_pkg::out_item_t skid_r;
  logic                main_free;

  assign main_free  = !main_vld_r || out_ch.ready;
  assign push_ready = !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (main_free) begin
      // Advance: skid moves up first to keep transaction order
      if (skid_vld_r) begin
        main_vld_r <= 1'b1;
        skid_vld_r <= push.valid;
      end else begin
        main_vld_r <= push.valid;
      end
    end else if (push.valid) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_vld_r) begin
        main_r <= skid_r;
        skid_r <= push.item;
      end else begin
        main_r <= push.item;
      end
    end else if (push.valid) begin
      skid_r <= push.item;
    end
  end

  assign out_ch.valid        = main_vld_r;
  assign out_ch.frame_byte   = main_r.frame_byte;
  assign out_ch.byte_index   = main_r.byte_index;
  assign out_ch.frame_end    = main_r.frame_end;
  assign out_ch.checksum_bad = main_r.checksum_bad;
  assign out_ch.forced_start = main_r.forced_start;

endmodule

>>> rtl/header_sync_frame_receiver.sv
// ----------------------------------------------------------------------------
// header_sync_frame_receiver
// Header-synchronised byte framer with an additive 16-bit checksum check.
// ----------------------------------------------------------------------------
// Bytes from a serial link enter one per transaction on in_ch. While hunting,
// a byte equal to header_byte opens a frame; if no header turns up, the byte
// on which the count of hunted bytes reaches skip_limit opens the frame
// anyway and every byte of that frame carries forced_start. Hunted bytes that
// open nothing give no output. Each of the frame_length frame bytes (header,
// payload, big-endian 16-bit trailer) leaves on out_ch with its index. A
// wrapping 16-bit sum covers every byte but the trailer; on the last byte it
// is compared with the trailer and checksum_bad reports a mismatch, then the
// block goes back to hunting. frame_length below 3 acts as 3; skip_limit 0
// acts as 1. Rate: one byte per clock cycle while in_ch.ready is high. The
// result is registered; all per-byte work (one compare chain and one 16-bit
// add) sits between the input handshake and the result register. The result
// register has a skid stage behind it, so in_ch.ready drops only when two
// results are held back by the sink. Write configuration only while idle.
// ----------------------------------------------------------------------------
module header_sync_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  hsfr_cfg_if.sink   cfg_ch,
  hsfr_in_if.sink    in_ch,
  hsfr_out_if.source out_ch
);

  // Configuration registers
  logic [hsfr_pkg::BYTE_W-1:0] header_byte_r;
  logic [hsfr_pkg::BYTE_W-1:0] frame_length_r;
  logic [hsfr_pkg::SKIP_W-1:0] skip_limit_r;

  // Framing state
  logic                        collecting_r,   collecting_nxt;
  logic [hsfr_pkg::SKIP_W-1:0] skip_count_r,   skip_count_nxt;
  logic [hsfr_pkg::BYTE_W-1:0] byte_count_r,   byte_count_nxt;
  logic [hsfr_pkg::SUM_W-1:0]  running_sum_r,  running_sum_nxt;
  logic [hsfr_pkg::BYTE_W-1:0] trailer_high_r, trailer_high_nxt;
  logic                        start_forced_r, start_forced_nxt;

  logic                        in_fire;
  logic                        push_ready;
  hsfr_pkg::out_push_t         push;

  logic [hsfr_pkg::BYTE_W-1:0] len_eff;
  logic [hsfr_pkg::BYTE_W-1:0] len_m2;
  logic [hsfr_pkg::SKIP_W-1:0] lim_eff;
  logic [hsfr_pkg::SKIP_W:0]   skip_inc;
  logic                        hdr_match;
  logic [hsfr_pkg::SUM_W-1:0]  trailer;

  // Configuration port never stalls
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_byte_r  <= hsfr_pkg::HEADER_BYTE_RST;
      frame_length_r <= hsfr_pkg::FRAME_LENGTH_RST;
      skip_limit_r   <= hsfr_pkg::SKIP_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      case (hsfr_pkg::cfg_reg_t'(cfg_ch.index))
        hsfr_pkg::REG_HEADER_BYTE:  header_byte_r  <= cfg_ch.data[hsfr_pkg::BYTE_W-1:0];
        hsfr_pkg::REG_FRAME_LENGTH: frame_length_r <= cfg_ch.data[hsfr_pkg::BYTE_W-1:0];
        hsfr_pkg::REG_SKIP_LIMIT:   skip_limit_r   <= cfg_ch.data[hsfr_pkg::SKIP_W-1:0];
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  assign in_ch.ready = push_ready;
  assign in_fire     = in_ch.valid && push_ready;

  // Clamp the configured values to their working range
  assign len_eff  = (frame_length_r < hsfr_pkg::MIN_FRAME_LENGTH)
                    ? hsfr_pkg::MIN_FRAME_LENGTH : frame_length_r;
  assign len_m2   = len_eff - hsfr_pkg::BYTE_W'(2);
  assign lim_eff  = (skip_limit_r == '0) ? hsfr_pkg::SKIP_W'(1) : skip_limit_r;
  assign skip_inc = {1'b0, skip_count_r} + (hsfr_pkg::SKIP_W+1)'(1);
  assign hdr_match = (in_ch.rx_byte == header_byte_r);
  assign trailer   = {trailer_high_r, in_ch.rx_byte};

  always_comb begin
    collecting_nxt   = collecting_r;
    skip_count_nxt   = skip_count_r;
    byte_count_nxt   = byte_count_r;
    running_sum_nxt  = running_sum_r;
    trailer_high_nxt = trailer_high_r;
    start_forced_nxt = start_forced_r;

    push.valid             = 1'b0;
    push.item.frame_byte   = in_ch.rx_byte;
    push.item.byte_index   = byte_count_r;
    push.item.frame_end    = 1'b0;
    push.item.checksum_bad = 1'b0;
    push.item.forced_start = start_forced_r;

    if (in_fire) begin
      if (!collecting_r) begin
        if (!hdr_match && (skip_inc < {1'b0, lim_eff})) begin
          // Still hunting: count the byte, no result
          skip_count_nxt = skip_inc[hsfr_pkg::SKIP_W-1:0];
        end else begin
          // Open a frame on a header match or on the limit byte
          push.valid             = 1'b1;
          push.item.byte_index   = '0;
          push.item.forced_start = !hdr_match;
          start_forced_nxt       = !hdr_match;
          collecting_nxt         = 1'b1;
          skip_count_nxt         = '0;
          byte_count_nxt         = hsfr_pkg::BYTE_W'(1);
          running_sum_nxt        = {{(hsfr_pkg::SUM_W-hsfr_pkg::BYTE_W){1'b0}},
                                    in_ch.rx_byte};
          trailer_high_nxt       = '0;
        end
      end else begin
        push.valid = 1'b1;
        if (byte_count_r < len_m2) begin
          // Payload byte: add into the running sum
          running_sum_nxt = running_sum_r +
                            {{(hsfr_pkg::SUM_W-hsfr_pkg::BYTE_W){1'b0}}, in_ch.rx_byte};
          byte_count_nxt  = byte_count_r + hsfr_pkg::BYTE_W'(1);
        end else if (byte_count_r == len_m2) begin
          // High trailer byte: hold it for the final compare
          trailer_high_nxt = in_ch.rx_byte;
          byte_count_nxt   = byte_count_r + hsfr_pkg::BYTE_W'(1);
        end else begin
          // Last byte: check the trailer and go back to hunting
          push.item.frame_end    = 1'b1;
          push.item.checksum_bad = (trailer != running_sum_r);
          collecting_nxt         = 1'b0;
          skip_count_nxt         = '0;
          byte_count_nxt         = '0;
          running_sum_nxt        = '0;
          trailer_high_nxt       = '0;
          start_forced_nxt       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r   <= 1'b0;
      skip_count_r   <= '0;
      byte_count_r   <= '0;
      running_sum_r  <= '0;
      trailer_high_r <= '0;
      start_forced_r <= 1'b0;
    end else begin
      collecting_r   <= collecting_nxt;
      skip_count_r   <= skip_count_nxt;
      byte_count_r   <= byte_count_nxt;
      running_sum_r  <= running_sum_nxt;
      trailer_high_r <= trailer_high_nxt;
      start_forced_r <= start_forced_nxt;
    end
  end

  hsfr_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

endmodule

>>> test/header_sync_frame_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// header_sync_frame_receiver_tb
// Self-checking bench for the header-sync frame receiver.
// ----------------------------------------------------------------------------
// The bench carries its own model of the framer: it follows the hunt, the
// frame count, the running sum and the trailer. It queues the frame byte
// that each accepted received byte should give. A monitor compares every
// frame byte that leaves the block with the oldest queued one, field by
// field. Directed tests cover the register reset values, length changes
// inside a frame, the shortest lengths, a header on the skip-limit byte and
// the widest skip limit. A long sink hold-off drives the block until it stalls
// its input when full. Random traffic then mixes well-formed frames, broken
// trailers and noise over many register settings.
// ----------------------------------------------------------------------------
module header_sync_frame_receiver_tb;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned RANDOM_RX_BYTES = 800;

  logic clk = 1'b0;
  logic rst_n;

  hsfr_cfg_if cfg_bus ();
  hsfr_in_if  rx_bus ();
  hsfr_out_if frame_bus ();

  header_sync_frame_receiver u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_bus),
    .in_ch  (rx_bus),
    .out_ch (frame_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies held by the model
  logic [hsfr_pkg::BYTE_W-1:0] m_header;
  logic [hsfr_pkg::BYTE_W-1:0] m_length;
  logic [hsfr_pkg::SKIP_W-1:0] m_limit;

  // Framer state held by the model
  logic                        m_collecting;
  logic [hsfr_pkg::SKIP_W-1:0] m_skip;
  logic [hsfr_pkg::BYTE_W-1:0] m_count;
  logic [hsfr_pkg::SUM_W-1:0]  m_sum;
  logic [hsfr_pkg::BYTE_W-1:0] m_trail_hi;
  logic                        m_forced;

  hsfr_pkg::out_item_t expected_q[$];
  int unsigned         rx_bytes;
  int unsigned         mismatch_count = 0;
  int unsigned         quiet_cycles;

  bit          pace_traffic;   // when clear, neither side idles
  bit          rx_offering;    // shadow of rx_bus.valid as last driven
  int unsigned sink_wait;
  bit          hold_seq;       // toggle to ask the sink for a long hold-off
  bit          hold_seen;      // last request taken up by the sink

  // --------------------------------------------------------------------------
  // Model of the framer
  // --------------------------------------------------------------------------

  // Lengths below the minimum behave as the minimum
  function automatic int unsigned active_length();
    return (m_length < hsfr_pkg::MIN_FRAME_LENGTH) ? int'(hsfr_pkg::MIN_FRAME_LENGTH)
                                                   : int'(m_length);
  endfunction

  // Advance the model by one received byte; queue the frame byte it gives
  task automatic track_rx_byte(input logic [hsfr_pkg::BYTE_W-1:0] b);
    hsfr_pkg::out_item_t item;
    int unsigned         frame_len;
    int unsigned         hunt_limit;
    int unsigned         hunted;
    bit                  gives_result;
    frame_len    = active_length();
    hunt_limit   = (m_limit == 0) ? 1 : int'(m_limit);
    gives_result = 1'b1;
    item         = '0;
    item.frame_byte = b;
    if (!m_collecting) begin
      hunted = int'(m_skip) + 1;
      if (b != m_header && hunted < hunt_limit) begin
        // Still hunting: count the byte and drop it
        m_skip       = hunted[hsfr_pkg::SKIP_W-1:0];
        gives_result = 1'b0;
      end else begin
        // Open a frame; forced unless the byte matched the header
        m_forced     = (b != m_header);
        m_collecting = 1'b1;
        m_skip       = '0;
        m_count      = 8'd1;
        m_sum        = {8'd0, b};
        m_trail_hi   = '0;
        item.forced_start = m_forced;
      end
    end else begin
      item.byte_index   = m_count;
      item.forced_start = m_forced;
      if (m_count < frame_len - 2) begin
        m_sum   = m_sum + {8'd0, b};
        m_count = m_count + 8'd1;
      end else if (m_count == frame_len - 2) begin
        m_trail_hi = b;
        m_count    = m_count + 8'd1;
      end else begin
        // Last byte: compare the trailer with the sum, then go back to hunting
        item.frame_end    = 1'b1;
        item.checksum_bad = ({m_trail_hi, b} != m_sum);
        m_collecting = 1'b0;
        m_skip       = '0;
        m_count      = '0;
        m_sum        = '0;
        m_trail_hi   = '0;
        m_forced     = 1'b0;
      end
    end
    if (gives_result) begin
      expected_q.push_back(item);
    end
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one received byte, hold it until taken, then update the model.
  // Valid stays high on return so that back-to-back bytes need no drop.
  task automatic send_byte(input logic [hsfr_pkg::BYTE_W-1:0] b);
    int unsigned gap;
    gap = pace_traffic ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      if (rx_offering) begin
        rx_bus.valid <= 1'b0;
        rx_offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    rx_offering = 1'b1;
    do @(posedge clk); while (!(rx_bus.valid && rx_bus.ready));
    rx_bytes++;
    track_rx_byte(b);
  endtask

  // Stop offering, wait for every queued frame byte, then let the block settle
  task automatic wait_frames_drained();
    if (rx_offering) begin
      rx_bus.valid <= 1'b0;
      rx_offering = 1'b0;
    end
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; valid is left high for a following write
  task automatic write_reg(input hsfr_pkg::cfg_reg_t idx,
                           input logic [hsfr_pkg::CFG_DAT_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    case (idx)
      hsfr_pkg::REG_HEADER_BYTE:  m_header = data[hsfr_pkg::BYTE_W-1:0];
      hsfr_pkg::REG_FRAME_LENGTH: m_length = data[hsfr_pkg::BYTE_W-1:0];
      hsfr_pkg::REG_SKIP_LIMIT:   m_limit  = data[hsfr_pkg::SKIP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic release_cfg();
    cfg_bus.valid <= 1'b0;
  endtask

  // Write all three registers; the unused upper data bits carry junk
  task automatic configure(input logic [hsfr_pkg::BYTE_W-1:0] header,
                           input logic [hsfr_pkg::BYTE_W-1:0] length,
                           input logic [hsfr_pkg::SKIP_W-1:0] limit);
    write_reg(hsfr_pkg::REG_HEADER_BYTE, {8'($urandom_range(0, 255)), header});
    write_reg(hsfr_pkg::REG_FRAME_LENGTH, {8'($urandom_range(0, 255)), length});
    write_reg(hsfr_pkg::REG_SKIP_LIMIT, limit);
    release_cfg();
  endtask

  // Finish the open frame: random payload, then the trailer from the sum
  task automatic send_frame_tail(input bit good_sum);
    logic [hsfr_pkg::BYTE_W-1:0] b;
    while (m_collecting) begin
      if (m_count < active_length() - 2)
        b = 8'($urandom_range(0, 255));
      else if (m_count == active_length() - 2)
        b = m_sum[15:8];
      else if (good_sum)
        b = m_sum[7:0];
      else
        b = m_sum[7:0] ^ (8'd1 << $urandom_range(0, 7));
      send_byte(b);
    end
  endtask

  // Pick the next byte from where the framer stands: mostly what a real
  // sender would put there, now and then something else
  function automatic logic [hsfr_pkg::BYTE_W-1:0] pick_rx_byte(
      input int unsigned header_pct);
    logic [hsfr_pkg::BYTE_W-1:0] b;
    int unsigned                 roll;
    b    = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (!m_collecting) begin
      if (roll < header_pct)
        b = m_header;
      else if (b == m_header && roll < 90)
        b = b ^ (8'd1 << $urandom_range(0, 7));
    end else if (m_count == active_length() - 2 && roll < 85) begin
      b = m_sum[15:8];
    end else if (m_count >= active_length() - 1 && roll < 85) begin
      b = m_sum[7:0];
    end
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Sink side: random stalls per frame byte, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      frame_bus.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (frame_bus.valid && frame_bus.ready)
        sink_wait = pace_traffic ? $urandom_range(0, 7) : 0;
      if (hold_seen != hold_seq) begin
        sink_wait = HOLD_OFF_CYCLES;
        hold_seen = hold_seq;
      end
      if (sink_wait != 0) begin
        frame_bus.ready <= 1'b0;
        sink_wait--;
      end else begin
        frame_bus.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [hsfr_pkg::BYTE_W-1:0] want,
                             input logic [hsfr_pkg::BYTE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_frame_bytes
    hsfr_pkg::out_item_t want;
    if (rst_n && frame_bus.valid && frame_bus.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected frame byte, expected none, got byte %0h index %0d",
                 $time, frame_bus.frame_byte, frame_bus.byte_index);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("frame_byte", want.frame_byte, frame_bus.frame_byte);
        check_field("byte_index", want.byte_index, frame_bus.byte_index);
        check_field("frame_end", 8'(want.frame_end), 8'(frame_bus.frame_end));
        check_field("checksum_bad", 8'(want.checksum_bad), 8'(frame_bus.checksum_bad));
        check_field("forced_start", 8'(want.forced_start), 8'(frame_bus.forced_start));
      end
    end
  end

  // Abort when no transaction of any kind completes for too long
  always @(posedge clk) begin
    if (!rst_n || (rx_bus.valid && rx_bus.ready) || (frame_bus.valid && frame_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: header 0, length 31, skip limit 100. Hunt a non-header byte
  // up to the limit for a forced start, then open a frame with a zero header.
  task automatic test_reset_values();
    repeat (100) send_byte(8'h5A);
    send_frame_tail(1'b1);
    send_byte(8'h00);
    wait_frames_drained();
  endtask

  // Shorten the frame while one is open: first so that the next byte is the
  // trailer high byte, then so that the next byte lies past the end
  task automatic test_length_change_mid_frame();
    write_reg(hsfr_pkg::REG_FRAME_LENGTH, 16'd3);
    release_cfg();
    send_frame_tail(1'b1);
    wait_frames_drained();
    configure(8'hA5, 8'd10, 16'd16);
    send_byte(8'hA5);
    repeat (5) send_byte(8'($urandom_range(0, 255)));
    wait_frames_drained();
    write_reg(hsfr_pkg::REG_FRAME_LENGTH, 16'd4);
    release_cfg();
    send_byte(8'($urandom_range(0, 255)));
    wait_frames_drained();
  endtask

  // Lengths below the minimum, a zero skip limit and the byte extremes
  task automatic test_short_frames();
    configure(8'hFF, 8'd0, 16'd0);
    send_byte(8'h00);          // skip limit zero: first hunted byte opens, forced
    send_frame_tail(1'b1);
    send_byte(8'hFF);
    send_frame_tail(1'b0);
    wait_frames_drained();
    configure(8'hFF, 8'd1, 16'd0);
    send_byte(8'hFF);
    send_frame_tail(1'b1);
    wait_frames_drained();
    configure(8'hFF, 8'd2, 16'd0);
    send_byte(8'h7F);
    send_frame_tail(1'b0);
    wait_frames_drained();
  endtask

  // A header on the limit byte is a normal start; a miss there is forced
  task automatic test_header_on_limit_byte();
    configure(8'h3C, 8'd5, 16'd3);
    send_byte(8'hC3);
    send_byte(8'h3D);
    send_byte(8'h3C);
    send_frame_tail(1'b1);
    repeat (3) send_byte(8'h00);
    send_frame_tail(1'b0);
    wait_frames_drained();
  endtask

  // Widest skip limit with a header well inside it, then the longest frame,
  // without idling to keep it quick
  task automatic test_long_hunt();
    pace_traffic = 1'b0;
    configure(8'h81, 8'd255, 16'hFFFF);
    repeat (40) send_byte(8'h7E);
    send_byte(8'h81);
    send_frame_tail(1'b1);
    wait_frames_drained();
    pace_traffic = 1'b1;
  endtask

  // Hold the sink off while a whole frame is offered back to back, so the
  // block fills and stalls its input; then wait for every frame byte
  task automatic test_backpressure();
    configure(8'h55, 8'd40, 16'd4);
    pace_traffic = 1'b0;
    hold_seq = !hold_seq;
    wait (hold_seen == hold_seq);
    send_byte(8'h55);
    send_frame_tail(1'b1);
    wait_frames_drained();
    pace_traffic = 1'b1;
  endtask

  // Phases of random settings; each sends mostly well-formed frames with
  // random content, plus broken trailers and noise
  task automatic test_random_traffic();
    int unsigned                 start_count;
    int unsigned                 target;
    int unsigned                 header_pct;
    int unsigned                 roll;
    logic [hsfr_pkg::BYTE_W-1:0] length;
    logic [hsfr_pkg::SKIP_W-1:0] limit;
    start_count = rx_bytes;
    while (rx_bytes - start_count < RANDOM_RX_BYTES) begin
      roll = $urandom_range(0, 19);
      if (roll == 0)      length = 8'($urandom_range(0, 2));
      else if (roll == 1) length = 8'd255;
      else if (roll < 4)  length = 8'($urandom_range(13, 64));
      else                length = 8'($urandom_range(3, 12));
      roll = $urandom_range(0, 19);
      if (roll == 0)      limit = 16'd0;
      else if (roll == 1) limit = 16'($urandom_range(0, 65535));
      else if (roll < 4)  limit = 16'($urandom_range(9, 300));
      else                limit = 16'($urandom_range(1, 8));
      header_pct   = $urandom_range(0, 60);
      pace_traffic = ($urandom_range(0, 3) != 0);
      target       = (length > 64) ? 300 : $urandom_range(20, 80);
      configure(8'($urandom_range(0, 255)), length, limit);
      repeat (target) send_byte(pick_rx_byte(header_pct));
      wait_frames_drained();
    end
    pace_traffic = 1'b1;
  endtask

  initial begin
    rst_n           <= 1'b0;
    rx_bus.valid    <= 1'b0;
    rx_bus.rx_byte  <= '0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.index   <= hsfr_pkg::REG_HEADER_BYTE;
    cfg_bus.data    <= '0;
    m_header       = hsfr_pkg::HEADER_BYTE_RST;
    m_length       = hsfr_pkg::FRAME_LENGTH_RST;
    m_limit        = hsfr_pkg::SKIP_LIMIT_RST;
    m_collecting   = 1'b0;
    m_skip         = '0;
    m_count        = '0;
    m_sum          = '0;
    m_trail_hi     = '0;
    m_forced       = 1'b0;
    rx_bytes       = 0;
    pace_traffic   = 1'b1;
    rx_offering    = 1'b0;
    hold_seq       = 1'b0;

    // Hold reset, then release it for good
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_length_change_mid_frame();
    test_short_frames();
    test_header_on_limit_byte();
    test_backpressure();
    test_long_hunt();
    test_random_traffic();

    wait_frames_drained();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
